// ----- rtl/sgdm_pkg.sv -----
// sgdm_pkg: shared types, constants and saturating helpers for the sgd momentum update block
// no dependencies; imported by every module of the block

package sgdm_pkg;

  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int FAC_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int MEM_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CFG_IDX_W = 3;
  localparam int NSTG      = 12;
  localparam int WR_STG    = 7;
  localparam int OQ_DEPTH  = 16;
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MINUS_DMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MOMENTUM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NESTEROV      = 3'd6;

  localparam logic [FAC_W-1:0] LR_RST  = 17'd655;
  localparam logic [FAC_W-1:0] OMD_RST = 17'd65536;

  typedef logic signed [DATA_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [FAC_W-1:0] learn_rate;
    logic [FAC_W-1:0] momentum_factor;
    logic [FAC_W-1:0] one_minus_damping;
    logic [FAC_W-1:0] decay_factor;
    logic             maximize_mode;
    logic             use_momentum;
    logic             nesterov_mode;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    val_t             param;
    val_t             g;
    val_t             mm;
    val_t             mbuf;
    logic             first;
  } stage_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    val_t             param;
  } oq_item_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? VAL_MIN : VAL_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? VAL_MIN : VAL_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic val_t sat_neg(val_t a);
    return (a == VAL_MIN) ? VAL_MAX : -a;
  endfunction

endpackage

// ----- rtl/sgd_momentum_update.sv -----
// sgd_momentum_update: top level, configuration registers and request credit control
// depends on sgdm_pkg, sgdm_core and sgdm_outq
//
// usage
//   in_*  : one request per parameter element (index, value, gradient, end-of-step flag),
//           valid/ready handshake
//   out_* : one result per request, in request order (index, updated value)
//   cfg_* : write-only registers, written while the block is idle
// path: a request runs through the update pipeline into the result queue; out_valid rises
//   once the queue holds the result
// throughput: one request per cycle while in_ready is high; the update pipeline never
//   stalls and the sixteen-entry result queue holds everything in flight
// with momentum on, a request whose index matches one still in the stages up to the
//   momentum write-back waits until that one has written its momentum entry back
//   (read-modify-write of the momentum memory, one read and one write port)
// receiver stall: results collect in the queue; once 16 requests are outstanding,
//   in_ready drops until results are taken
// reset: registers return to their defaults, first-pass flag set, queue empty;
//   the momentum memory is not cleared and needs no clearing time

module sgd_momentum_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sgdm_pkg::IDX_W-1:0]         in_elem_index,
  input  logic signed [sgdm_pkg::DATA_W-1:0] in_param_in,
  input  logic signed [sgdm_pkg::DATA_W-1:0] in_grad,
  input  logic                               in_last_of_step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sgdm_pkg::IDX_W-1:0]         out_index_out,
  output logic signed [sgdm_pkg::DATA_W-1:0] out_param_out,
  input  logic                               cfg_we,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgdm_pkg::FAC_W-1:0]         cfg_wdata
);
  import sgdm_pkg::*;

  cfg_t              cfg_r;
  logic              acc, pop, conflict, push;
  oq_item_t          push_item, out_item;
  logic [OQ_PTR_W:0] outst_r, outst_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learn_rate        <= LR_RST;
      cfg_r.momentum_factor   <= '0;
      cfg_r.one_minus_damping <= OMD_RST;
      cfg_r.decay_factor      <= '0;
      cfg_r.maximize_mode     <= 1'b0;
      cfg_r.use_momentum      <= 1'b0;
      cfg_r.nesterov_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE:    cfg_r.learn_rate        <= cfg_wdata;
        REG_MOMENTUM:      cfg_r.momentum_factor   <= cfg_wdata;
        REG_ONE_MINUS_DMP: cfg_r.one_minus_damping <= cfg_wdata;
        REG_DECAY:         cfg_r.decay_factor      <= cfg_wdata;
        REG_MAXIMIZE:      cfg_r.maximize_mode     <= cfg_wdata[0];
        REG_USE_MOMENTUM:  cfg_r.use_momentum      <= cfg_wdata[0];
        REG_NESTEROV:      cfg_r.nesterov_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // outstanding requests never exceed the queue depth
  assign in_ready = (outst_r < (OQ_PTR_W+1)'(OQ_DEPTH)) & ~conflict;
  assign acc      = in_valid & in_ready;
  assign pop      = out_valid & out_ready;

  always_comb begin
    case ({acc, pop})
      2'b10:   outst_nxt = outst_r + 1'b1;
      2'b01:   outst_nxt = outst_r - 1'b1;
      default: outst_nxt = outst_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else begin
      outst_r <= outst_nxt;
    end
  end

  sgdm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc       (acc),
    .in_idx    (in_elem_index),
    .in_param  (in_param_in),
    .in_grad   (in_grad),
    .in_last   (in_last_of_step),
    .conflict  (conflict),
    .push      (push),
    .push_item (push_item)
  );

  sgdm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .valid     (out_valid),
    .item      (out_item)
  );

  assign out_index_out = out_item.idx;
  assign out_param_out = out_item.param;

endmodule

// ----- rtl/sgdm_mulq.sv -----
// sgdm_mulq: two-stage value times factor multiply, rounded half away from zero, saturated
// depends on sgdm_pkg

module sgdm_mulq (
  input  logic                           clk,
  input  sgdm_pkg::val_t                 v,
  input  logic [sgdm_pkg::FAC_W-1:0]     f,
  output sgdm_pkg::val_t                 res
);
  import sgdm_pkg::*;

  localparam int PROD_W = DATA_W + FAC_W;
  localparam int RND_W  = PROD_W - FRAC_W;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

  logic [DATA_W-1:0] mag;
  logic [PROD_W-1:0] prod_nxt, prod_r;
  logic              neg_r;
  logic [PROD_W-1:0] sum;
  logic [RND_W-1:0]  rnd;
  logic [DATA_W-1:0] lim, rmag;
  val_t              res_nxt, res_r;

  // stage 1: magnitude and product
  always_comb begin
    mag      = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    prod_nxt = PROD_W'(mag) * PROD_W'(f);
  end

  // stage 2: round, clamp, restore sign
  always_comb begin
    sum     = prod_r + HALF;
    rnd     = sum[PROD_W-1:FRAC_W];
    lim     = neg_r ? DATA_W'(VAL_MIN) : DATA_W'(VAL_MAX);
    rmag    = (rnd > RND_W'(lim)) ? lim : rnd[DATA_W-1:0];
    res_nxt = neg_r ? -val_t'(rmag) : val_t'(rmag);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= v[DATA_W-1];
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

// ----- rtl/sgdm_core.sv -----
// sgdm_core: momentum memory and the fixed-latency update pipeline
// depends on sgdm_pkg and sgdm_mulq

module sgdm_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sgdm_pkg::cfg_t                cfg,
  input  logic                          acc,
  input  logic [sgdm_pkg::IDX_W-1:0]    in_idx,
  input  sgdm_pkg::val_t                in_param,
  input  sgdm_pkg::val_t                in_grad,
  input  logic                          in_last,
  output logic                          conflict,
  output logic                          push,
  output sgdm_pkg::oq_item_t            push_item
);
  import sgdm_pkg::*;

  logic [DATA_W-1:0] mom_mem [MEM_DEPTH];
  val_t              rd_data_r;
  logic              wr_en;

  logic [NSTG:1]     vld_r, vld_nxt;
  stage_t            st_r   [1:NSTG];
  stage_t            st_nxt [1:NSTG];
  logic              first_r;

  val_t              dec_res, mem_res, omd_res, nes_res, lr_res;
  logic              hit;

  // with momentum on, a request must wait while an older request to the same entry has not written back
  always_comb begin
    hit = 1'b0;
    for (int k = 1; k <= WR_STG; k++) begin
      if (vld_r[k] && (st_r[k].idx == in_idx)) begin
        hit = 1'b1;
      end
    end
    conflict = cfg.use_momentum & hit;
  end

  assign wr_en = vld_r[WR_STG] & cfg.use_momentum;

  always_ff @(posedge clk) begin
    rd_data_r <= val_t'(mom_mem[in_idx[ADDR_W-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mom_mem[st_r[WR_STG].idx[ADDR_W-1:0]] <= DATA_W'(st_r[WR_STG].mbuf);
    end
  end

  sgdm_mulq u_dec (.clk(clk), .v(st_r[1].param), .f(cfg.decay_factor),      .res(dec_res));
  sgdm_mulq u_mem (.clk(clk), .v(rd_data_r),     .f(cfg.momentum_factor),   .res(mem_res));
  sgdm_mulq u_omd (.clk(clk), .v(st_r[4].g),     .f(cfg.one_minus_damping), .res(omd_res));
  sgdm_mulq u_nes (.clk(clk), .v(st_r[7].mbuf),  .f(cfg.momentum_factor),   .res(nes_res));
  sgdm_mulq u_lr  (.clk(clk), .v(st_r[10].g),    .f(cfg.learn_rate),        .res(lr_res));

  always_comb begin
    vld_nxt = {vld_r[NSTG-1:1], acc};

    st_nxt[1].idx   = in_idx;
    st_nxt[1].param = in_param;
    st_nxt[1].g     = in_grad;
    st_nxt[1].mm    = '0;
    st_nxt[1].mbuf  = '0;
    st_nxt[1].first = first_r;
    for (int k = 2; k <= NSTG; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    // maximize negation
    st_nxt[2].g = cfg.maximize_mode ? sat_neg(st_r[1].g) : st_r[1].g;
    // weight decay, old momentum scaled
    st_nxt[4].g  = sat_add(st_r[3].g, dec_res);
    st_nxt[4].mm = mem_res;
    // new momentum entry
    st_nxt[7].mbuf = st_r[6].first ? st_r[6].g : sat_add(st_r[6].mm, omd_res);
    // gradient used for the step
    if (cfg.use_momentum) begin
      st_nxt[10].g = cfg.nesterov_mode ? sat_add(st_r[9].g, nes_res) : st_r[9].mbuf;
    end else begin
      st_nxt[10].g = st_r[9].g;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      first_r <= 1'b1;
    end else begin
      vld_r <= vld_nxt;
      if (acc && in_last) begin
        first_r <= 1'b0;
      end
    end
  end

  assign push            = vld_r[NSTG];
  assign push_item.idx   = st_r[NSTG].idx;
  assign push_item.param = sat_sub(st_r[NSTG].param, lr_res);

endmodule

// ----- rtl/sgdm_outq.sv -----
// sgdm_outq: result queue that absorbs the pipeline while the receiver stalls
// depends on sgdm_pkg

module sgdm_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sgdm_pkg::oq_item_t     push_item,
  input  logic                   pop,
  output logic                   valid,
  output sgdm_pkg::oq_item_t     item
);
  import sgdm_pkg::*;

  oq_item_t              q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OQ_PTR_W:0]     cnt_r, cnt_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  assign valid = (cnt_r != '0);
  assign item  = q_r[rd_ptr_r];

endmodule

// ----- dv/testbench.sv -----
// testbench for sgd_momentum_update: random and directed requests with a built-in predictor
// of the fixed-point sgd step, results checked in order; depends on sgdm_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import sgdm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint VMAX_L = 64'sd2147483647;
  localparam longint VMIN_L = -64'sd2147483648;
  localparam int LATENCY = 13;

  typedef struct {
    logic [IDX_W-1:0] idx;
    val_t             param;
  } update_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [IDX_W-1:0]     in_elem_index;
  val_t                 in_param_in;
  val_t                 in_grad;
  logic                 in_last_of_step;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_W-1:0]     out_index_out;
  val_t                 out_param_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FAC_W-1:0]     cfg_wdata;

  cfg_t             cur_cfg;
  val_t             mom_buf [MEM_DEPTH];
  bit               buf_written [MEM_DEPTH];
  logic [IDX_W-1:0] written_idx [$];
  logic [IDX_W-1:0] last_idx;
  bit               first_phase;
  update_t          pending_updates [$];
  update_t          want;
  int               mismatch_count;
  bit               idle_on;
  int               hold_left;

  sgd_momentum_update i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_elem_index   (in_elem_index),
    .in_param_in     (in_param_in),
    .in_grad         (in_grad),
    .in_last_of_step (in_last_of_step),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_index_out   (out_index_out),
    .out_param_out   (out_param_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // fixed-point helpers
  function automatic val_t clip_val(longint v);
    if (v > VMAX_L) return VAL_MAX;
    if (v < VMIN_L) return VAL_MIN;
    return val_t'(v);
  endfunction

  function automatic val_t add_clip(val_t a, val_t b);
    return clip_val(longint'(a) + longint'(b));
  endfunction

  function automatic val_t sub_clip(val_t a, val_t b);
    return clip_val(longint'(a) - longint'(b));
  endfunction

  function automatic val_t neg_clip(val_t a);
    return clip_val(-longint'(a));
  endfunction

  // value times unsigned q1.16 factor, rounded on the magnitude, saturated
  function automatic val_t scale_q(val_t v, logic [FAC_W-1:0] f);
    longint unsigned mag, lim, hi, lo, r, fl;
    logic neg;
    neg = v[DATA_W-1];
    mag = neg ? -longint'(v) : longint'(v);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    fl = 64'(f);
    hi = mag >> FRAC_W;
    lo = mag & 64'hFFFF;
    if (fl != 0 && hi > lim / fl) begin
      r = lim;
    end else begin
      r = hi * fl + ((lo * fl + 64'h8000) >> FRAC_W);
      if (r > lim) r = lim;
    end
    return neg ? val_t'(-longint'(r)) : val_t'(r);
  endfunction

  function automatic update_t predict_update(logic [IDX_W-1:0] idx, val_t p, val_t grad,
                                             logic last);
    update_t u;
    val_t g, b;
    g = grad;
    if (cur_cfg.maximize_mode) g = neg_clip(g);
    g = add_clip(g, scale_q(p, cur_cfg.decay_factor));
    if (cur_cfg.use_momentum) begin
      if (first_phase) b = g;
      else b = add_clip(scale_q(mom_buf[idx], cur_cfg.momentum_factor),
                        scale_q(g, cur_cfg.one_minus_damping));
      mom_buf[idx] = b;
      if (!buf_written[idx]) begin
        buf_written[idx] = 1'b1;
        written_idx.push_back(idx);
      end
      g = cur_cfg.nesterov_mode ? add_clip(g, scale_q(b, cur_cfg.momentum_factor)) : b;
    end
    u.idx = idx;
    u.param = sub_clip(p, scale_q(g, cur_cfg.learn_rate));
    if (last) first_phase = 1'b0;
    return u;
  endfunction

  function automatic val_t rand_val();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4: return val_t'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return val_t'($urandom());
    endcase
  endfunction

  function automatic logic [FAC_W-1:0] rand_factor();
    case ($urandom_range(5))
      0: return '0;
      1: return 17'h1FFFF;
      2: return 17'd65536;
      3: return FAC_W'($urandom_range(0, 4096));
      4: return FAC_W'($urandom_range(60000, 70000));
      default: return FAC_W'($urandom_range(0, 131071));
    endcase
  endfunction

  // after the first step a momentum read must hit an entry already written
  function automatic logic [IDX_W-1:0] pick_index();
    if (written_idx.size() > 0 && $urandom_range(3) == 0 && buf_written[last_idx])
      return last_idx;
    if (cur_cfg.use_momentum && !first_phase)
      return written_idx[$urandom_range(written_idx.size() - 1)];
    if (written_idx.size() > 0 && $urandom_range(1))
      return written_idx[$urandom_range(written_idx.size() - 1)];
    return IDX_W'($urandom_range(4095));
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] exp_val);
    $display("tb: mismatch on %s, got %h, want %h, at %0t", field, got, exp_val, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unrequested result", out_param_out, '0);
      end else begin
        want = pending_updates.pop_front();
        if (out_index_out !== want.idx)
          report_mismatch("index_out", DATA_W'(out_index_out), DATA_W'(want.idx));
        if (out_param_out !== want.param) report_mismatch("param_out", out_param_out, want.param);
      end
    end
  end

  // receiver side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !(idle_on && $urandom_range(99) < 16);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_req(logic [IDX_W-1:0] idx, val_t p, val_t g, logic last);
    while (idle_on && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_elem_index = idx;
    in_param_in = p;
    in_grad = g;
    in_last_of_step = last;
    do @(posedge clk); while (!in_ready);
    pending_updates.push_back(predict_update(idx, p, g, last));
    last_idx = idx;
    @(negedge clk);
  endtask

  task automatic send_random(bit allow_last);
    send_req(pick_index(), rand_val(), rand_val(), allow_last && $urandom_range(15) == 0);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (pending_updates.size() == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FAC_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_LEARN_RATE:    cur_cfg.learn_rate = data;
      REG_MOMENTUM:      cur_cfg.momentum_factor = data;
      REG_ONE_MINUS_DMP: cur_cfg.one_minus_damping = data;
      REG_DECAY:         cur_cfg.decay_factor = data;
      REG_MAXIMIZE:      cur_cfg.maximize_mode = data[0];
      REG_USE_MOMENTUM:  cur_cfg.use_momentum = data[0];
      REG_NESTEROV:      cur_cfg.nesterov_mode = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_flag(logic [CFG_IDX_W-1:0] idx, bit value);
    write_reg(idx, {(FAC_W-1)'($urandom_range(0, 65535)), value});
  endtask

  task automatic rand_config();
    drain();
    write_reg(REG_LEARN_RATE, ($urandom_range(3) == 0) ? rand_factor()
                                                       : FAC_W'($urandom_range(0, 2000)));
    write_reg(REG_MOMENTUM, rand_factor());
    write_reg(REG_ONE_MINUS_DMP, rand_factor());
    write_reg(REG_DECAY, ($urandom_range(2) == 0) ? '0 : rand_factor());
    write_flag(REG_MAXIMIZE, 1'($urandom_range(1)));
    write_flag(REG_USE_MOMENTUM, $urandom_range(9) < 6);
    write_flag(REG_NESTEROV, 1'($urandom_range(1)));
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, FAC_W'($urandom()));
  endtask

  task automatic test_defaults();
    send_req('0, VAL_MAX, VAL_MAX, 1'b0);
    send_req(12'hFFF, VAL_MIN, VAL_MIN, 1'b0);
    send_req(12'hAAA, '0, VAL_MIN, 1'b0);
    send_req(12'h555, 32'sh0001_0000, 32'sh0000_8000, 1'b0);
  endtask

  // fills momentum entries while the first step is still open
  task automatic test_first_pass();
    drain();
    write_reg(REG_MOMENTUM, 17'd58982);
    write_flag(REG_USE_MOMENTUM, 1'b1);
    send_req('0, VAL_MAX, VAL_MIN, 1'b0);
    send_req(12'hFFF, VAL_MIN, VAL_MAX, 1'b0);
    send_req(12'hAAA, rand_val(), rand_val(), 1'b0);
    send_req(12'h555, rand_val(), rand_val(), 1'b0);
    repeat (25) send_random(1'b0);
    drain();
    write_flag(REG_NESTEROV, 1'b1);
    write_reg(REG_DECAY, 17'd655);
    repeat (25) send_random(1'b0);
    send_req(12'h555, rand_val(), rand_val(), 1'b1);
  endtask

  task automatic test_directed_ops();
    drain();
    write_flag(REG_USE_MOMENTUM, 1'b0);
    write_flag(REG_MAXIMIZE, 1'b1);
    write_reg(REG_DECAY, '0);
    write_reg(REG_LEARN_RATE, 17'd65536);
    send_req(12'h123, VAL_MAX, VAL_MIN, 1'b0);
    send_req(12'hFFF, '0, VAL_MIN, 1'b1);
    drain();
    write_reg(REG_DECAY, 17'h1FFFF);
    write_reg(REG_LEARN_RATE, 17'h1FFFF);
    write_reg(REG_UNUSED, 17'h1FFFF);
    send_req(12'h000, VAL_MAX, VAL_MAX, 1'b0);
    send_req(12'h7FF, VAL_MIN, VAL_MIN, 1'b0);
    send_req(12'h800, VAL_MIN, VAL_MAX, 1'b0);
    drain();
    write_flag(REG_MAXIMIZE, 1'b0);
    write_reg(REG_DECAY, '0);
    write_reg(REG_LEARN_RATE, 17'd6554);
    write_reg(REG_MOMENTUM, 17'h1FFFF);
    write_reg(REG_ONE_MINUS_DMP, '0);
    write_flag(REG_USE_MOMENTUM, 1'b1);
    write_flag(REG_NESTEROV, 1'b0);
    send_req('0, rand_val(), rand_val(), 1'b0);
    send_req('0, rand_val(), rand_val(), 1'b0);
    send_req(12'hFFF, rand_val(), VAL_MAX, 1'b0);
    drain();
    write_flag(REG_NESTEROV, 1'b1);
    write_reg(REG_ONE_MINUS_DMP, 17'h1FFFF);
    send_req(12'hFFF, rand_val(), VAL_MIN, 1'b0);
    send_req(12'hFFF, rand_val(), rand_val(), 1'b1);
    send_req(12'hAAA, rand_val(), rand_val(), 1'b0);
  endtask

  task automatic test_random_configs();
    repeat (12) begin
      rand_config();
      repeat (130) send_random(1'b1);
    end
  endtask

  // receiver stalls long enough for the result queue to fill and in_ready to drop
  task automatic test_backpressure();
    drain();
    idle_on = 1'b0;
    hold_left = 300;
    repeat (60) send_random(1'b1);
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle();
    rand_config();
    idle_on = 1'b0;
    repeat (250) send_random(1'b1);
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_elem_index = '0;
    in_param_in = '0;
    in_grad = '0;
    in_last_of_step = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatch_count = 0;
    idle_on = 1'b1;
    hold_left = 0;
    last_idx = '0;
    first_phase = 1'b1;
    cur_cfg = '{learn_rate: LR_RST, momentum_factor: '0, one_minus_damping: OMD_RST,
                decay_factor: '0, maximize_mode: 1'b0, use_momentum: 1'b0,
                nesterov_mode: 1'b0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_defaults();
    test_first_pass();
    test_directed_ops();
    test_random_configs();
    test_backpressure();
    test_no_idle();

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sgdm_pkg.sv
rtl/sgdm_mulq.sv
rtl/sgdm_core.sv
rtl/sgdm_outq.sv
rtl/sgd_momentum_update.sv
dv/testbench.sv
